// ----- hw/rtl/motor_frequency_ramp_supervisor_unit_defines.svh -----
// Assertion helpers for the ramp supervisor RTL.
`ifndef MOTOR_FREQUENCY_RAMP_SUPERVISOR_UNIT_DEFINES_SVH
`define MOTOR_FREQUENCY_RAMP_SUPERVISOR_UNIT_DEFINES_SVH

// Same-cycle implication, masked while reset is low.
`define MFRS_ASSERT_IMP(name, clk, rst_n, ante, cons, msg) \
    name: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// Next-cycle implication, masked while reset is low.
`define MFRS_ASSERT_NXT(name, clk, rst_n, ante, cons, msg) \
    name: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

// ----- hw/rtl/mfrs_pkg.sv -----
package mfrs_pkg;

    localparam int SPEED_STEPS_DEF = 8;
    localparam int FREQ_W          = 16;
    localparam int MASK_W          = 8;
    localparam int SIDX_W          = 4;
    localparam int SAMPLE_W        = 16;
    localparam int CFG_IDX_W       = 3;
    localparam int CFG_DATA_W      = 16;

    // Emergency source bit that reports limits back to normal
    localparam int SAFETY_SRC_BIT  = 1;

    typedef enum logic [2:0] {
        OP_TICK     = 3'd0,
        OP_START    = 3'd1,
        OP_STOP     = 3'd2,
        OP_ESTOP    = 3'd3,
        OP_RELEASE  = 3'd4,
        OP_SPEED    = 3'd5,
        OP_MEASURE  = 3'd6
    } t_op;

    typedef enum logic [2:0] {
        MODE_IDLE         = 3'd0,
        MODE_RAMPING      = 3'd1,
        MODE_AT_SPEED     = 3'd2,
        MODE_BRAKING      = 3'd3,
        MODE_EMERGENCY    = 3'd4,
        MODE_EMERG_CLEARED = 3'd5
    } t_mode;

    typedef enum logic [1:0] {
        DIR_NONE = 2'd0,
        DIR_UP   = 2'd1,
        DIR_DOWN = 2'd2
    } t_dir;

    typedef enum logic [1:0] {
        EVT_NONE     = 2'd0,
        EVT_EXCEEDED = 2'd1,
        EVT_NORMAL   = 2'd2
    } t_event;

    typedef enum logic [1:0] {
        TMODE_ZERO   = 2'd0,
        TMODE_LINEAR = 2'd1,
        TMODE_QUAD   = 2'd2
    } t_tmode;

    typedef enum logic [CFG_IDX_W-1:0] {
        CFG_ACCEL_STEP   = 3'd0,
        CFG_DECEL_STEP   = 3'd1,
        CFG_VOLT_FLOOR   = 3'd2,
        CFG_CURR_CEILING = 3'd3,
        CFG_FULL_SPEED   = 3'd4,
        CFG_TABLE_MODE   = 3'd5
    } t_cfg_idx;

    typedef struct packed {
        logic [FREQ_W-1:0]   accel_step;
        logic [FREQ_W-1:0]   decel_step;
        logic [SAMPLE_W-1:0] volt_floor;
        logic [SAMPLE_W-1:0] curr_ceiling;
        logic [FREQ_W-1:0]   full_speed;
        logic [FREQ_W-1:0]   full_speed_div;  // full_speed / speed steps
        t_tmode              table_mode;
    } t_cfg;

    typedef struct packed {
        t_op                 op;
        logic [MASK_W-1:0]   signal_mask;
        logic [SIDX_W-1:0]   speed_index;
        logic [SAMPLE_W-1:0] voltage_sample;
        logic [SAMPLE_W-1:0] current_sample;
    } t_item;

    typedef struct packed {
        logic [FREQ_W-1:0] present_frequency;
        logic [FREQ_W-1:0] target_frequency;
        t_mode             mode;
        t_event            safety_event;
        logic              all_released;
        logic              rejected;
    } t_result;

endpackage

// ----- hw/rtl/mfrs_speed_table.sv -----
module mfrs_speed_table
    import mfrs_pkg::*;
#(
    parameter int SPEED_STEPS = SPEED_STEPS_DEF,
    localparam int IDX_W = $clog2(SPEED_STEPS)
) (
    input  t_cfg              i_cfg,
    input  logic [IDX_W-1:0]  i_index,
    output logic [FREQ_W-1:0] o_entry
);

    localparam int DEPTH  = 1 << IDX_W;
    localparam int LMUL_W = $clog2(SPEED_STEPS + 1);
    localparam int QSH    = 32;
    localparam int COEF_W = QSH + 1;
    localparam int QP_W   = FREQ_W + COEF_W + 1;
    localparam int LP_W   = FREQ_W + LMUL_W;

    // Divide by S*S through a reciprocal; the (S-k)^2 factor is folded into
    // per-entry constants and a single rounding half is added to the product.
    localparam logic [63:0] QDIV  = 64'(SPEED_STEPS * SPEED_STEPS);
    localparam logic [63:0] QREC  = ((64'd1 << QSH) + QDIV - 64'd1) / QDIV;
    localparam logic [63:0] QHALF = (QDIV / 64'd2) * QREC;

    logic [COEF_W-1:0] q_coef  [DEPTH];
    logic [LMUL_W-1:0] lin_mul [DEPTH];
    logic [QP_W-1:0]   q_prod;
    logic [QP_W-QSH-1:0] q_val;
    logic [FREQ_W-1:0] q_entry;
    logic [LP_W-1:0]   lin_prod;
    logic [FREQ_W-1:0] lin_entry;

    for (genvar k = 0; k < DEPTH; k++) begin : g_coef
        if (k < SPEED_STEPS) begin : g_used
            assign q_coef[k]  = COEF_W'(64'((SPEED_STEPS - k) * (SPEED_STEPS - k)) * QREC);
            assign lin_mul[k] = LMUL_W'(SPEED_STEPS - k);
        end else begin : g_pad
            assign q_coef[k]  = '0;
            assign lin_mul[k] = '0;
        end
    end

    assign q_prod   = QP_W'(i_cfg.full_speed) * QP_W'(q_coef[i_index]) + QP_W'(QHALF);
    assign q_val    = q_prod[QP_W-1:QSH];
    assign q_entry  = (q_val == '0) ? FREQ_W'(1) : q_val[FREQ_W-1:0];

    assign lin_prod  = LP_W'(i_cfg.full_speed_div) * LP_W'(lin_mul[i_index]);
    assign lin_entry = (i_index == '0) ? i_cfg.full_speed : lin_prod[FREQ_W-1:0];

    always_comb begin
        case (i_cfg.table_mode)
            TMODE_LINEAR: o_entry = lin_entry;
            TMODE_QUAD:   o_entry = q_entry;
            default:      o_entry = '0;
        endcase
    end

endmodule

// ----- hw/rtl/mfrs_cfg_regs.sv -----
module mfrs_cfg_regs
    import mfrs_pkg::*;
#(
    parameter int SPEED_STEPS = SPEED_STEPS_DEF
) (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  logic                  i_cfg_wr_en,
    input  logic [CFG_IDX_W-1:0]  i_cfg_index,
    input  logic [CFG_DATA_W-1:0] i_cfg_data,
    output t_cfg                  o_cfg
);

    // Reciprocal for data / S, exact over the 16-bit range
    localparam int LSH  = 20;
    localparam int LREC = ((1 << LSH) + SPEED_STEPS - 1) / SPEED_STEPS;
    localparam int LP_W = CFG_DATA_W + LSH;

    t_cfg             r_cfg;
    logic [LP_W-1:0]  div_prod;

    assign div_prod = LP_W'(i_cfg_data) * LP_W'(LREC);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg.accel_step     <= FREQ_W'(1);
            r_cfg.decel_step     <= FREQ_W'(1);
            r_cfg.volt_floor     <= '0;
            r_cfg.curr_ceiling   <= '1;
            r_cfg.full_speed     <= '0;
            r_cfg.full_speed_div <= '0;
            r_cfg.table_mode     <= TMODE_ZERO;
        end else if (i_cfg_wr_en) begin
            unique case (i_cfg_index)
                CFG_ACCEL_STEP:   r_cfg.accel_step   <= i_cfg_data;
                CFG_DECEL_STEP:   r_cfg.decel_step   <= i_cfg_data;
                CFG_VOLT_FLOOR:   r_cfg.volt_floor   <= i_cfg_data;
                CFG_CURR_CEILING: r_cfg.curr_ceiling <= i_cfg_data;
                CFG_FULL_SPEED: begin
                    r_cfg.full_speed     <= i_cfg_data;
                    r_cfg.full_speed_div <= div_prod[LP_W-1:LSH];
                end
                CFG_TABLE_MODE:   r_cfg.table_mode <= t_tmode'(i_cfg_data[1:0]);
                default: ;
            endcase
        end
    end

    assign o_cfg = r_cfg;

endmodule

// ----- hw/rtl/mfrs_ramp_core.sv -----
`include "motor_frequency_ramp_supervisor_unit_defines.svh"

module mfrs_ramp_core
    import mfrs_pkg::*;
#(
    parameter int SPEED_STEPS = SPEED_STEPS_DEF
) (
    input  logic    i_clk,
    input  logic    i_rst_n,
    input  t_cfg    i_cfg,
    input  logic    i_fire,
    input  t_item   i_item,
    input  logic    i_out_stall,
    output logic    o_out_valid,
    output t_result o_result
);

    localparam int IDX_W = $clog2(SPEED_STEPS);

    logic [FREQ_W-1:0] r_now, n_now;
    logic [FREQ_W-1:0] r_goal, n_goal;
    t_mode             r_mode, n_mode;
    t_dir              r_dir, n_dir;
    logic [MASK_W-1:0] r_bits, n_bits;
    logic [IDX_W-1:0]  r_sel, n_sel;
    logic              r_out_valid;
    t_result           r_result, n_result;

    logic [IDX_W-1:0]  tbl_index;
    logic [FREQ_W-1:0] tbl_entry;
    logic [FREQ_W:0]   up_sum;
    logic [FREQ_W:0]   dn_limit;
    logic [FREQ_W-1:0] up_now;
    logic [FREQ_W-1:0] dn_now;
    logic [MASK_W-1:0] rel_bits;
    logic              idx_bad;
    logic              fault;

    assign idx_bad   = {1'b0, i_item.speed_index} >= (SIDX_W + 1)'(SPEED_STEPS);
    assign tbl_index = (i_item.op == OP_SPEED) ? i_item.speed_index[IDX_W-1:0] : r_sel;

    mfrs_speed_table #(
        .SPEED_STEPS (SPEED_STEPS)
    ) u_table (
        .i_cfg   (i_cfg),
        .i_index (tbl_index),
        .o_entry (tbl_entry)
    );

    // One ramp step toward the goal, clamped at the goal
    assign up_sum   = {1'b0, r_now} + {1'b0, i_cfg.accel_step};
    assign dn_limit = {1'b0, r_goal} + {1'b0, i_cfg.decel_step};
    assign up_now   = (r_now == r_goal) ? r_now :
                      (up_sum > {1'b0, r_goal}) ? r_goal : up_sum[FREQ_W-1:0];
    assign dn_now   = (r_now == r_goal) ? r_now :
                      ({1'b0, r_now} < dn_limit) ? r_goal : (r_now - i_cfg.decel_step);

    assign rel_bits = r_bits & ~i_item.signal_mask;
    assign fault    = (i_item.current_sample > i_cfg.curr_ceiling) ||
                      (i_item.voltage_sample < i_cfg.volt_floor);

    // Next state
    always_comb begin
        n_now  = r_now;
        n_goal = r_goal;
        n_mode = r_mode;
        n_dir  = r_dir;
        n_bits = r_bits;
        n_sel  = r_sel;
        unique case (i_item.op)
            OP_TICK: begin
                if (r_dir == DIR_UP) begin
                    n_now = up_now;
                    if (up_now == r_goal) begin
                        n_mode = MODE_AT_SPEED;
                        n_dir  = DIR_NONE;
                    end
                end else if (r_dir == DIR_DOWN) begin
                    n_now = dn_now;
                    if (dn_now == r_goal) begin
                        if (r_mode == MODE_BRAKING) begin
                            n_mode = MODE_IDLE;
                        end else if (r_mode != MODE_EMERGENCY) begin
                            n_mode = MODE_AT_SPEED;
                        end
                        n_dir = DIR_NONE;
                    end
                end
            end
            OP_START: begin
                if (r_mode != MODE_EMERGENCY) begin
                    n_goal = tbl_entry;
                    n_mode = MODE_RAMPING;
                    n_dir  = DIR_UP;
                end
            end
            OP_STOP: begin
                if (r_mode == MODE_EMERG_CLEARED) begin
                    n_mode = MODE_IDLE;
                end else if (r_mode != MODE_EMERGENCY) begin
                    n_goal = '0;
                    n_mode = MODE_BRAKING;
                    n_dir  = DIR_DOWN;
                end
            end
            OP_ESTOP: begin
                n_dir  = DIR_NONE;
                n_goal = '0;
                n_now  = '0;
                n_mode = MODE_EMERGENCY;
                n_bits = r_bits | i_item.signal_mask;
            end
            OP_RELEASE: begin
                n_bits = rel_bits;
                if (rel_bits == '0) begin
                    n_mode = MODE_EMERG_CLEARED;
                end
            end
            OP_SPEED: begin
                if (!idx_bad && r_mode != MODE_EMERGENCY) begin
                    n_sel  = i_item.speed_index[IDX_W-1:0];
                    n_goal = tbl_entry;
                    if (r_now > tbl_entry) begin
                        n_dir  = DIR_DOWN;
                        n_mode = MODE_RAMPING;
                    end else if (r_now < tbl_entry) begin
                        n_dir  = DIR_UP;
                        n_mode = MODE_RAMPING;
                    end else begin
                        n_dir  = DIR_NONE;
                        n_mode = MODE_AT_SPEED;
                    end
                end
            end
            default: ;
        endcase
    end

    // Result fields
    always_comb begin
        n_result                   = '0;
        n_result.present_frequency = n_now;
        n_result.target_frequency  = n_goal;
        n_result.mode              = n_mode;
        n_result.safety_event      = EVT_NONE;
        unique case (i_item.op)
            OP_RELEASE: n_result.all_released = (rel_bits == '0);
            OP_SPEED:   n_result.rejected     = idx_bad;
            OP_MEASURE: begin
                if (fault) begin
                    if (r_mode != MODE_EMERGENCY) begin
                        n_result.safety_event = EVT_EXCEEDED;
                    end
                end else if (r_mode == MODE_EMERGENCY && r_bits[SAFETY_SRC_BIT]) begin
                    n_result.safety_event = EVT_NORMAL;
                end
            end
            default: ;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_now  <= '0;
            r_goal <= '0;
            r_mode <= MODE_IDLE;
            r_dir  <= DIR_NONE;
            r_bits <= '0;
            r_sel  <= '0;
        end else if (i_fire) begin
            r_now  <= n_now;
            r_goal <= n_goal;
            r_mode <= n_mode;
            r_dir  <= n_dir;
            r_bits <= n_bits;
            r_sel  <= n_sel;
        end
    end

    // Result register: load on fire, drop once taken
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (i_fire) begin
            r_out_valid <= 1'b1;
        end else if (!i_out_stall) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_fire) begin
            r_result <= n_result;
        end
    end

    assign o_out_valid = r_out_valid;
    assign o_result    = r_result;

    `MFRS_ASSERT_IMP(a_emerg_halted, i_clk, i_rst_n, r_mode == MODE_EMERGENCY,
        r_now == '0 && r_goal == '0 && r_dir == DIR_NONE, "emergency with motion left")
    `MFRS_ASSERT_IMP(a_ramping_has_dir, i_clk, i_rst_n, r_mode == MODE_RAMPING,
        r_dir != DIR_NONE, "ramping without a direction")
    `MFRS_ASSERT_IMP(a_braking_down, i_clk, i_rst_n, r_mode == MODE_BRAKING,
        r_dir == DIR_DOWN, "braking without a down ramp")
    `MFRS_ASSERT_NXT(a_estop_mode, i_clk, i_rst_n,
        i_rst_n && i_fire && i_item.op == OP_ESTOP,
        r_mode == MODE_EMERGENCY && r_out_valid, "emergency stop not taken")

endmodule

// ----- hw/rtl/motor_frequency_ramp_supervisor_unit.sv -----
// Flow: an accepted item is registered in the input register, processed into the
//   result register once the result slot is free, and its result is then offered.
// Throughput: one item per cycle while the output is not stalled; the ramp, table
//   lookup and event logic sit between the input register and the result register.
// Reset: synchronous, active low; clears frequency, goal, mode, emergency bits,
//   selected speed, both valid flags, and loads the configuration defaults.
module motor_frequency_ramp_supervisor_unit
    import mfrs_pkg::*;
#(
    parameter int SPEED_STEPS = SPEED_STEPS_DEF
) (
    input  logic                  i_clk,
    input  logic                  i_rst_n,

    input  logic                  i_cfg_wr_en,
    input  logic [CFG_IDX_W-1:0]  i_cfg_index,
    input  logic [CFG_DATA_W-1:0] i_cfg_data,

    input  logic                  i_in_valid,
    output logic                  o_in_stall,
    input  logic [2:0]            i_operation,
    input  logic [MASK_W-1:0]     i_signal_mask,
    input  logic [SIDX_W-1:0]     i_speed_index,
    input  logic [SAMPLE_W-1:0]   i_voltage_sample,
    input  logic [SAMPLE_W-1:0]   i_current_sample,

    output logic                  o_out_valid,
    input  logic                  i_out_stall,
    output logic [FREQ_W-1:0]     o_present_frequency,
    output logic [FREQ_W-1:0]     o_target_frequency,
    output logic [2:0]            o_mode_code,
    output logic [1:0]            o_safety_event,
    output logic                  o_all_released,
    output logic                  o_rejected
);

    t_cfg    cfg;
    t_item   r_item;
    logic    r_in_valid;
    logic    out_busy;
    logic    fire;
    t_result result;

    mfrs_cfg_regs #(
        .SPEED_STEPS (SPEED_STEPS)
    ) u_cfg (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cfg_wr_en (i_cfg_wr_en),
        .i_cfg_index (i_cfg_index),
        .i_cfg_data  (i_cfg_data),
        .o_cfg       (cfg)
    );

    // Result slot still holds an item that is not taken
    assign out_busy   = o_out_valid && i_out_stall;
    assign fire       = r_in_valid && !out_busy;
    assign o_in_stall = r_in_valid && out_busy;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid <= 1'b0;
        end else if (!o_in_stall) begin
            r_in_valid <= i_in_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_in_valid && !o_in_stall) begin
            r_item.op             <= t_op'(i_operation);
            r_item.signal_mask    <= i_signal_mask;
            r_item.speed_index    <= i_speed_index;
            r_item.voltage_sample <= i_voltage_sample;
            r_item.current_sample <= i_current_sample;
        end
    end

    mfrs_ramp_core #(
        .SPEED_STEPS (SPEED_STEPS)
    ) u_core (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cfg       (cfg),
        .i_fire      (fire),
        .i_item      (r_item),
        .i_out_stall (i_out_stall),
        .o_out_valid (o_out_valid),
        .o_result    (result)
    );

    assign o_present_frequency = result.present_frequency;
    assign o_target_frequency  = result.target_frequency;
    assign o_mode_code         = result.mode;
    assign o_safety_event      = result.safety_event;
    assign o_all_released      = result.all_released;
    assign o_rejected          = result.rejected;

endmodule
